[sv/vss_pkg.sv]
package vss_pkg;

  // stream field widths
  localparam int unsigned OpW        = 2;
  localparam int unsigned TimeW      = 64;
  localparam int unsigned DepthW     = 16;
  localparam int unsigned FirstW     = 10;
  localparam int unsigned EndIdxW    = 11;

  // input tdata layout, lowest bit first
  localparam int unsigned EntryEndLsb    = 0;
  localparam int unsigned EntryDepthLsb  = EntryEndLsb + TimeW;
  localparam int unsigned WinStartLsb    = EntryDepthLsb + DepthW;
  localparam int unsigned WinEndLsb      = WinStartLsb + TimeW;
  localparam int unsigned InDataW        = WinEndLsb + TimeW;

  // output tdata layout, padded to whole bytes
  localparam int unsigned FirstLsb       = 0;
  localparam int unsigned EndIdxLsb      = FirstLsb + FirstW;
  localparam int unsigned OutFieldsW     = EndIdxLsb + EndIdxW;
  localparam int unsigned OutDataW       = ((OutFieldsW + 7) / 8) * 8;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // one table row: root flag above the end timestamp
  typedef struct packed {
    logic             root;
    logic [TimeW-1:0] end_time;
  } entry_t;

  typedef struct packed {
    logic               span_found;
    logic [FirstW-1:0]  first_index;
    logic [EndIdxW-1:0] end_index;
  } result_t;

endpackage

[sv/vss_table.sv]
module vss_table #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  vss_pkg::entry_t wr_data_i,
  input  logic [AW-1:0]   rd_addr_a_i,
  input  logic [AW-1:0]   rd_addr_b_i,
  output vss_pkg::entry_t rd_data_a_o,
  output vss_pkg::entry_t rd_data_b_o
);

  vss_pkg::entry_t mem_q [DEPTH];
  vss_pkg::entry_t rd_a_q;
  vss_pkg::entry_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[rd_addr_a_i];
    rd_b_q <= mem_q[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

[sv/vss_ctrl.sv]
module vss_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned AW            = 10,
  parameter int unsigned CW            = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [vss_pkg::OpW-1:0]     op_i,
  input  logic [vss_pkg::TimeW-1:0]   entry_end_i,
  input  logic                        entry_root_i,
  input  logic [vss_pkg::TimeW-1:0]   window_start_i,
  input  logic [vss_pkg::TimeW-1:0]   window_end_i,
  output logic                        wr_en_o,
  output logic [AW-1:0]               wr_addr_o,
  output vss_pkg::entry_t             wr_data_o,
  output logic [AW-1:0]               rd_addr_a_o,
  output logic [AW-1:0]               rd_addr_b_o,
  input  vss_pkg::entry_t             rd_data_a_i,
  input  vss_pkg::entry_t             rd_data_b_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output vss_pkg::result_t            res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_EMIT
  } state_e;

  localparam logic [CW-1:0] TableMax = CW'(TABLE_ENTRIES);

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [vss_pkg::TimeW-1:0] key_start_q, key_start_d;
  logic [vss_pkg::TimeW-1:0] key_end_q, key_end_d;
  // unit a: lower bound, then first index; unit b: upper bound, then end index
  logic [CW-1:0] lo_a_q, lo_a_d, len_a_q, len_a_d;
  logic [CW-1:0] lo_b_q, lo_b_d, len_b_q, len_b_d;
  logic done_a_q, done_a_d, done_b_q, done_b_d;
  vss_pkg::result_t res_q, res_d;

  logic [CW-1:0] half_a, half_b, mid_a, mid_b;
  logic [31:0] first_w, last_w;
  logic accept;

  assign half_a = len_a_q >> 1;
  assign half_b = len_b_q >> 1;
  assign mid_a  = lo_a_q + half_a;
  assign mid_b  = lo_b_q + half_b;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o       = res_q;
  assign accept      = in_valid_i && in_ready_o;

  assign wr_en_o   = accept && (op_i == vss_pkg::OP_APPEND) && (count_q < TableMax);
  assign wr_addr_o = count_q[AW-1:0];
  assign wr_data_o = '{root: entry_root_i, end_time: entry_end_i};

  assign rd_addr_a_o = (state_q == ST_WALK_RD) ? lo_a_q[AW-1:0] : mid_a[AW-1:0];
  assign rd_addr_b_o = (state_q == ST_WALK_RD) ? lo_b_q[AW-1:0] : mid_b[AW-1:0];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    key_start_d = key_start_q;
    key_end_d   = key_end_q;
    lo_a_d      = lo_a_q;
    len_a_d     = len_a_q;
    lo_b_d      = lo_b_q;
    len_b_d     = len_b_q;
    done_a_d    = done_a_q;
    done_b_d    = done_b_q;
    res_d       = res_q;
    first_w     = 32'(lo_a_q);
    last_w      = 32'(lo_b_q);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_i)
            vss_pkg::OP_APPEND: begin
              if (count_q < TableMax) begin
                count_d = count_q + CW'(1);
              end
            end
            vss_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            vss_pkg::OP_QUERY: begin
              key_start_d = window_start_i;
              key_end_d   = window_end_i;
              lo_a_d      = '0;
              len_a_d     = count_q;
              lo_b_d      = '0;
              len_b_d     = count_q;
              state_d     = ST_SRCH_RD;
            end
            default: ;
          endcase
        end
      end
      ST_SRCH_RD: begin
        if ((len_a_q == '0) && (len_b_q == '0)) begin
          if (lo_a_q >= count_q) begin
            res_d   = '0;
            state_d = ST_EMIT;
          end else begin
            done_a_d = 1'b0;
            done_b_d = 1'b0;
            state_d  = ST_WALK_RD;
          end
        end else begin
          state_d = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (len_a_q != '0) begin
          if (rd_data_a_i.end_time < key_start_q) begin
            lo_a_d  = mid_a + CW'(1);
            len_a_d = len_a_q - half_a - CW'(1);
          end else begin
            len_a_d = half_a;
          end
        end
        if (len_b_q != '0) begin
          if (rd_data_b_i.end_time <= key_end_q) begin
            lo_b_d  = mid_b + CW'(1);
            len_b_d = len_b_q - half_b - CW'(1);
          end else begin
            len_b_d = half_b;
          end
        end
        state_d = ST_SRCH_RD;
      end
      ST_WALK_RD: begin
        state_d = ST_WALK_CMP;
      end
      ST_WALK_CMP: begin
        if (!done_a_q) begin
          if ((lo_a_q == '0) || rd_data_a_i.root) begin
            done_a_d = 1'b1;
          end else begin
            lo_a_d = lo_a_q - CW'(1);
          end
        end
        if (!done_b_q) begin
          if (lo_b_q >= count_q) begin
            done_b_d = 1'b1;
          end else begin
            lo_b_d   = lo_b_q + CW'(1);
            done_b_d = rd_data_b_i.root;
          end
        end
        first_w = 32'(lo_a_d);
        last_w  = 32'(lo_b_d);
        if (done_a_d && done_b_d) begin
          res_d.span_found  = 1'b1;
          res_d.first_index = first_w[vss_pkg::FirstW-1:0];
          res_d.end_index   = last_w[vss_pkg::EndIdxW-1:0];
          state_d           = ST_EMIT;
        end else begin
          state_d = ST_WALK_RD;
        end
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      done_a_q <= 1'b0;
      done_b_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_a_q <= done_a_d;
      done_b_q <= done_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_start_q <= key_start_d;
    key_end_q   <= key_end_d;
    lo_a_q      <= lo_a_d;
    len_a_q     <= len_a_d;
    lo_b_q      <= lo_b_d;
    len_b_q     <= len_b_d;
    res_q       <= res_d;
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= TableMax)
    else $error("entry count above table size");

  a_probe_a_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH_RD) && (len_a_q != '0) |-> mid_a < count_q)
    else $error("lower bound probe outside filled entries");

  a_probe_b_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH_RD) && (len_b_q != '0) |-> mid_b < count_q)
    else $error("upper bound probe outside filled entries");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == vss_pkg::OP_CLEAR) |=> count_q == '0)
    else $error("clear did not empty the table");

  a_miss_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_q.span_found |-> (res_q.first_index == '0) && (res_q.end_index == '0))
    else $error("not-found result carries nonzero indices");

endmodule

[sv/visible_span_search.sv]
// append and clear are done in the idle state, so the block stays ready for a new item
// query: both bound searches run in parallel, S probe steps (at most
//   clog2(entries + 1)), then the walks to a depth-zero entry; no walk on a miss
// each probe and walk step is a read state, then a compare state on the registered data
// one item at a time; the output register frees the input side while a result waits
// reset clears the entry count and control state only; table contents stay undefined
module visible_span_search #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_end, entry_depth, window_start, window_end
  input  logic [vss_pkg::InDataW-1:0]   s_axis_tdata,
  // operation
  input  logic [vss_pkg::OpW-1:0]       s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // first_index, end_index, zero pad
  output logic [vss_pkg::OutDataW-1:0]  m_axis_tdata,
  // span_found
  output logic                          m_axis_tuser
);

  // index width for the table, count width holds the full size too
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  // unpack the input transfer
  logic [vss_pkg::TimeW-1:0]  entry_end;
  logic [vss_pkg::DepthW-1:0] entry_depth;
  logic [vss_pkg::TimeW-1:0]  window_start;
  logic [vss_pkg::TimeW-1:0]  window_end;

  assign entry_end    = s_axis_tdata[vss_pkg::EntryEndLsb +: vss_pkg::TimeW];
  assign entry_depth  = s_axis_tdata[vss_pkg::EntryDepthLsb +: vss_pkg::DepthW];
  assign window_start = s_axis_tdata[vss_pkg::WinStartLsb +: vss_pkg::TimeW];
  assign window_end   = s_axis_tdata[vss_pkg::WinEndLsb +: vss_pkg::TimeW];

  // table port wiring
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  vss_pkg::entry_t wr_data;
  logic [AW-1:0]   rd_addr_a;
  logic [AW-1:0]   rd_addr_b;
  vss_pkg::entry_t rd_data_a;
  vss_pkg::entry_t rd_data_b;

  // result hand-off to the output register
  logic             res_valid;
  logic             res_ready;
  vss_pkg::result_t res;

  logic             out_valid_q, out_valid_d;
  vss_pkg::result_t out_res_q, out_res_d;

  // sequencer: append/clear bookkeeping, two parallel bound searches, walks
  vss_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW),
    .CW            (CW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .op_i           (s_axis_tuser),
    .entry_end_i    (entry_end),
    .entry_root_i   (entry_depth == '0),
    .window_start_i (window_start),
    .window_end_i   (window_end),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_addr_a_o    (rd_addr_a),
    .rd_addr_b_o    (rd_addr_b),
    .rd_data_a_i    (rd_data_a),
    .rd_data_b_i    (rd_data_b),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // end timestamps and depth-zero flags, one write and two read ports
  vss_table #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  // output register takes a new result when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  // pack the output transfer
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.span_found;
  assign m_axis_tdata  = vss_pkg::OutDataW'({out_res_q.end_index, out_res_q.first_index});

endmodule
